// ----- rtl/scan_polar_to_cartesian_assert.svh -----
// Assertion macros used by the scan converter top level.
`ifndef SCAN_POLAR_TO_CARTESIAN_ASSERT_SVH
`define SCAN_POLAR_TO_CARTESIAN_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scan converter check failed");

// Next-cycle implication, checked outside reset.
`define SPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scan converter check failed");

`endif

// ----- rtl/spc_pkg.sv -----
// Shared types, constants and the arctangent table of the scan converter.
package spc_pkg;

  localparam int MAX_SAMPLES  = 4096;
  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;

  localparam int RANGE_W  = 16;
  localparam int INTEN_W  = 16;
  localparam int ANGLE_W  = 32;
  localparam int COUNT_W  = 13;
  localparam int COORD_W  = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam int XY_W    = 36;
  localparam int Z_W     = 33;
  localparam int STEP_W  = $clog2(TABLE_LEN);
  localparam int GAIN_W  = 30;
  localparam int PROD_W  = RANGE_W + GAIN_W;
  localparam int FRAC_BITS = 16;

  localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;
  localparam logic [COUNT_W-1:0] KEEP_CAP =
      COUNT_W'((MAX_SAMPLES < 8191) ? MAX_SAMPLES : 8191);
  localparam logic [STEP_W-1:0] LAST_STEP =
      STEP_W'(((CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN) - 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE_START = 2'd0,
    REG_ANGLE_STEP  = 2'd1,
    REG_RANGE_LIMIT = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_ITER,
    BK_DONE
  } back_state_t;

  // One classified sample on its way to the rotator.
  typedef struct packed {
    logic [RANGE_W-1:0] range_mm;
    logic [INTEN_W-1:0] intensity;
    logic [ANGLE_W-1:0] angle;
    logic               kept;
    logic [COUNT_W-1:0] kept_count;
    logic               scan_end;
  } spc_item_t;

  // atan(2^-i), 2^32 per turn.
  function automatic logic [ANGLE_W-1:0] atan_lut(input logic [STEP_W-1:0] i);
    logic [ANGLE_W-1:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/scan_polar_to_cartesian.sv -----
// Lidar scan polar-to-Cartesian converter, one result beat per sample beat.
// A kept sample is pushed into the queue, popped in BK_IDLE, scaled in BK_MUL, rotated in
// BK_ITER and loaded into the output register in BK_DONE; a dropped one skips BK_MUL and BK_ITER.
// The single shared CORDIC stage runs one rotation step a cycle and takes one kept sample
// at a time; the queue can accept new samples meanwhile until it is full.
// Reset (synchronous, active low) clears angle, count, queue and angle registers and
// sets the range limit to its maximum; a two-beat queue decouples front and rotator.
`include "scan_polar_to_cartesian_assert.svh"
module scan_polar_to_cartesian (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [spc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [spc_pkg::RANGE_W-1:0] in_range_mm,
  input  logic [spc_pkg::INTEN_W-1:0] in_intensity,
  input  logic                        in_first_sample,
  input  logic                        in_last_sample,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_kept,
  output logic signed [spc_pkg::COORD_W-1:0] out_x_mm,
  output logic signed [spc_pkg::COORD_W-1:0] out_y_mm,
  output logic [spc_pkg::INTEN_W-1:0] out_point_intensity,
  output logic [spc_pkg::COUNT_W-1:0] out_kept_count,
  output logic                        out_scan_end
);
  import spc_pkg::*;

  logic      q_push, q_pop, q_full, q_empty;
  spc_item_t push_item, pop_item;

  spc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_range_mm     (in_range_mm),
    .in_intensity    (in_intensity),
    .in_first_sample (in_first_sample),
    .in_last_sample  (in_last_sample),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_item          (push_item)
  );

  spc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  spc_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_item              (pop_item),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kept            (out_kept),
    .out_x_mm            (out_x_mm),
    .out_y_mm            (out_y_mm),
    .out_point_intensity (out_point_intensity),
    .out_kept_count      (out_kept_count),
    .out_scan_end        (out_scan_end)
  );

  // a dropped sample carries no coordinates and no intensity
  `SPC_ASSERT_NOW(a_drop_zero, clk, rst_n, out_valid && !out_kept,
    out_x_mm == '0 && out_y_mm == '0 && out_point_intensity == '0)
  // coordinates stay inside the saturation bounds
  `SPC_ASSERT_NOW(a_coord_bound, clk, rst_n, out_valid,
    out_x_mm != -(COORD_W'(65536)) && out_y_mm != -(COORD_W'(65536)))
  // the queue is never popped while empty
  `SPC_ASSERT_NOW(a_no_underflow, clk, rst_n, q_pop, !q_empty)
  // a push into an empty queue leaves it non-empty next cycle
  `SPC_ASSERT_NEXT(a_push_lands, clk, rst_n, q_push && q_empty, !q_empty)

endmodule

// ----- rtl/spc_front.sv -----
// Front end: config registers, sample angle tracking, range gate and kept count.
module spc_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [spc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [spc_pkg::RANGE_W-1:0] in_range_mm,
  input  logic [spc_pkg::INTEN_W-1:0] in_intensity,
  input  logic                        in_first_sample,
  input  logic                        in_last_sample,
  input  logic                        q_full,
  output logic                        q_push,
  output spc_pkg::spc_item_t          q_item
);
  import spc_pkg::*;

  logic [ANGLE_W-1:0] angle_start_r;
  logic [ANGLE_W-1:0] angle_step_r;
  logic [RANGE_W-1:0] range_limit_r;
  logic [ANGLE_W-1:0] sample_angle_r, sample_angle_nxt;
  logic [COUNT_W-1:0] kept_total_r, kept_total_nxt;
  logic [ANGLE_W-1:0] cur_angle;
  logic [COUNT_W-1:0] count_base;
  logic               keep;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    cur_angle  = in_first_sample ? angle_start_r : sample_angle_r;
    count_base = in_first_sample ? '0 : kept_total_r;
    keep       = (in_range_mm != '0) && (in_range_mm < range_limit_r);
    sample_angle_nxt = sample_angle_r;
    kept_total_nxt   = kept_total_r;
    if (q_push) begin
      sample_angle_nxt = cur_angle + angle_step_r;
      kept_total_nxt   = count_base;
      if (keep && (count_base < KEEP_CAP)) begin
        kept_total_nxt = count_base + COUNT_W'(1);
      end
    end
    q_item.range_mm   = in_range_mm;
    q_item.intensity  = keep ? in_intensity : '0;
    q_item.angle      = cur_angle;
    q_item.kept       = keep;
    q_item.kept_count = kept_total_nxt;
    q_item.scan_end   = in_last_sample;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_start_r  <= '0;
      angle_step_r   <= '0;
      range_limit_r  <= '1;
      sample_angle_r <= '0;
      kept_total_r   <= '0;
    end else begin
      sample_angle_r <= sample_angle_nxt;
      kept_total_r   <= kept_total_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_ANGLE_START: angle_start_r <= cfg_wdata[ANGLE_W-1:0];
          REG_ANGLE_STEP:  angle_step_r  <= cfg_wdata[ANGLE_W-1:0];
          REG_RANGE_LIMIT: range_limit_r <= cfg_wdata[RANGE_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- rtl/spc_queue.sv -----
// Short FIFO of classified samples between the front end and the rotator.
module spc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  spc_pkg::spc_item_t push_item,
  input  logic               pop,
  output spc_pkg::spc_item_t pop_item,
  output logic               full,
  output logic               empty
);
  import spc_pkg::*;

  spc_item_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;

  assign full     = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_item = mem_r[rd_ptr_r];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - QCNT_W'(1);
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/spc_back.sv -----
// Back end: iterative CORDIC rotator, quadrant fix-up, rounding and output register.
module spc_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  spc_pkg::spc_item_t          q_item,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_kept,
  output logic signed [spc_pkg::COORD_W-1:0] out_x_mm,
  output logic signed [spc_pkg::COORD_W-1:0] out_y_mm,
  output logic [spc_pkg::INTEN_W-1:0] out_point_intensity,
  output logic [spc_pkg::COUNT_W-1:0] out_kept_count,
  output logic                        out_scan_end
);
  import spc_pkg::*;

  back_state_t state_r, state_nxt;

  spc_item_t               item_r, item_nxt;
  logic [1:0]              quad_r, quad_nxt;
  logic signed [Z_W-1:0]   z_r, z_nxt;
  logic signed [XY_W-1:0]  x_r, x_nxt;
  logic signed [XY_W-1:0]  y_r, y_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic                    out_load;

  logic [1:0]              quad_in;
  logic [ANGLE_W-1:0]      resid;
  logic [PROD_W-1:0]       prod;
  logic [PROD_W-1:0]       prod_rnd;
  logic signed [XY_W-1:0]  dx, dy;
  logic signed [Z_W-1:0]   atan_z;
  logic signed [XY_W-1:0]  rx, ry;
  logic signed [COORD_W-1:0] fx, fy;

  function automatic logic signed [COORD_W-1:0] round_sat(input logic signed [XY_W-1:0] v);
    logic signed [XY_W:0] t;
    logic signed [XY_W:0] s;
    logic signed [COORD_W-1:0] r;
    t = {v[XY_W-1], v} + (XY_W+1)'(1 << (FRAC_BITS - 1));
    s = t >>> FRAC_BITS;
    if (s > (XY_W+1)'(65535)) begin
      r = COORD_W'(65535);
    end else if (s < -(XY_W+1)'(65535)) begin
      r = -COORD_W'(65535);
    end else begin
      r = s[COORD_W-1:0];
    end
    return r;
  endfunction

  assign out_valid = out_valid_r;

  always_comb begin
    // nearest quarter turn and the residual inside it
    quad_in  = 2'((q_item.angle + 32'h20000000) >> 30);
    resid    = q_item.angle - {quad_in, 30'd0};
    prod     = PROD_W'(item_r.range_mm) * PROD_W'(GAIN_Q30);
    prod_rnd = prod + PROD_W'(1 << 13);
    dx       = y_r >>> step_r;
    dy       = x_r >>> step_r;
    atan_z   = Z_W'(atan_lut(step_r));
    case (quad_r)
      2'd0: begin rx = x_r;  ry = y_r;  end
      2'd1: begin rx = -y_r; ry = x_r;  end
      2'd2: begin rx = -x_r; ry = -y_r; end
      default: begin rx = y_r; ry = -x_r; end
    endcase
    fx = item_r.kept ? round_sat(rx) : '0;
    fy = item_r.kept ? round_sat(ry) : '0;
  end

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    quad_nxt  = quad_r;
    z_nxt     = z_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    step_nxt  = step_r;
    q_pop     = 1'b0;
    out_load  = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          item_nxt = q_item;
          quad_nxt = quad_in;
          z_nxt    = Z_W'($signed(resid));
          // dropped samples skip the rotation
          state_nxt = q_item.kept ? BK_MUL : BK_DONE;
        end
      end
      BK_MUL: begin
        x_nxt     = XY_W'(prod_rnd[PROD_W-1:14]);
        y_nxt     = '0;
        step_nxt  = '0;
        state_nxt = BK_ITER;
      end
      BK_ITER: begin
        if (!z_r[Z_W-1]) begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - atan_z;
        end else begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + atan_z;
        end
        step_nxt = step_r + STEP_W'(1);
        if (step_r == LAST_STEP) begin
          state_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    quad_r <= quad_nxt;
    z_r    <= z_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    step_r <= step_nxt;
    if (out_load) begin
      out_kept            <= item_r.kept;
      out_x_mm            <= fx;
      out_y_mm            <= fy;
      out_point_intensity <= item_r.intensity;
      out_kept_count      <= item_r.kept_count;
      out_scan_end        <= item_r.scan_end;
    end
  end

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the lidar scan polar-to-Cartesian converter.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import spc_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int ROT_STEPS = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam int COUNT_CAP = (MAX_SAMPLES < 8191) ? MAX_SAMPLES : 8191;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam longint unsigned GAIN = 64'd652032874;
  localparam longint COORD_LIM = 65535;

  // atan(2^-i), 2^32 per turn
  localparam longint ATAN_STEP [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  typedef struct {
    bit                         kept;
    logic signed [COORD_W-1:0]  x_mm;
    logic signed [COORD_W-1:0]  y_mm;
    logic [INTEN_W-1:0]         intensity;
    logic [COUNT_W-1:0]         count;
    bit                         scan_end;
  } point_t;

  typedef struct {
    bit                     is_write;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    logic [RANGE_W-1:0]     range_mm;
    logic [INTEN_W-1:0]     intensity;
    bit                     first;
    bit                     last;
    bit                     typed;
    point_t                 want;
  } step_row_t;

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [RANGE_W-1:0]       in_range_mm = '0;
  logic [INTEN_W-1:0]       in_intensity = '0;
  logic                     in_first_sample = 1'b0;
  logic                     in_last_sample = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     out_kept;
  logic signed [COORD_W-1:0] out_x_mm;
  logic signed [COORD_W-1:0] out_y_mm;
  logic [INTEN_W-1:0]       out_point_intensity;
  logic [COUNT_W-1:0]       out_kept_count;
  logic                     out_scan_end;

  // converter shadow state
  logic [ANGLE_W-1:0] start_reg = '0;
  logic [ANGLE_W-1:0] step_reg = '0;
  logic [RANGE_W-1:0] limit_reg = '1;
  logic [ANGLE_W-1:0] next_angle = '0;
  logic [COUNT_W-1:0] kept_run = '0;

  point_t pending_points[$];
  int     mismatches = 0;
  int     cycle_count = 0;
  bit     idle_on = 1'b1;

  scan_polar_to_cartesian dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= idle_on && ($urandom_range(99) < 23);
  end

  task automatic note_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want)
      note_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  always @(posedge clk) begin : result_monitor
    point_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        note_mismatch("result beat with nothing outstanding");
      end else begin
        want = pending_points.pop_front();
        check_field("kept", out_kept, want.kept);
        check_field("x_mm", longint'(out_x_mm), longint'(want.x_mm));
        check_field("y_mm", longint'(out_y_mm), longint'(want.y_mm));
        check_field("point_intensity", out_point_intensity, want.intensity);
        check_field("kept_count", out_kept_count, want.count);
        check_field("scan_end", out_scan_end, want.scan_end);
      end
    end
  end

  function automatic logic signed [COORD_W-1:0] to_mm(input longint v);
    longint t;
    t = (v + 64'sd32768) >>> 16;
    if (t > COORD_LIM) t = COORD_LIM;
    if (t < -COORD_LIM) t = -COORD_LIM;
    return t[COORD_W-1:0];
  endfunction

  // CORDIC rotation of (r, 0) by ang: fold to nearest quarter turn, then rotate the rest
  function automatic void rotate_point(input logic [RANGE_W-1:0] r, input logic [ANGLE_W-1:0] ang,
                                       output longint ox, output longint oy);
    logic [ANGLE_W-1:0] biased;
    logic [ANGLE_W-1:0] rem;
    logic [1:0]         quad;
    longint             x, y, z, dx, dy;
    biased = ang + 32'h2000_0000;
    quad = biased[31:30];
    rem = ang - {quad, 30'd0};
    z = longint'($signed(rem));
    x = longint'((64'(r) * GAIN + 64'd8192) >> 14);
    y = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_STEP[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_STEP[i];
      end
    end
    case (quad)
      2'd0: begin ox = x;  oy = y;  end
      2'd1: begin ox = -y; oy = x;  end
      2'd2: begin ox = -x; oy = -y; end
      default: begin ox = y; oy = -x; end
    endcase
  endfunction

  function automatic point_t predict_point(input step_row_t row);
    point_t             p;
    logic [ANGLE_W-1:0] ang;
    longint             fx, fy;
    if (row.first) begin
      ang = start_reg;
      kept_run = '0;
    end else begin
      ang = next_angle;
    end
    next_angle = ang + step_reg;
    p = '{default: 0};
    p.kept = (row.range_mm != 0) && (row.range_mm < limit_reg);
    if (p.kept) begin
      rotate_point(row.range_mm, ang, fx, fy);
      p.x_mm = to_mm(fx);
      p.y_mm = to_mm(fy);
      p.intensity = row.intensity;
      if (kept_run < COUNT_CAP) kept_run = kept_run + 1'b1;
    end
    p.count = kept_run;
    p.scan_end = row.last;
    return p;
  endfunction

  function automatic step_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    step_row_t t;
    t = '{default: 0};
    t.is_write = 1'b1;
    t.idx = idx;
    t.data = data;
    return t;
  endfunction

  function automatic step_row_t sample_row(input logic [RANGE_W-1:0] r,
                                           input logic [INTEN_W-1:0] inten,
                                           input bit first, input bit last);
    step_row_t t;
    t = '{default: 0};
    t.range_mm = r;
    t.intensity = inten;
    t.first = first;
    t.last = last;
    return t;
  endfunction

  // dropped sample: coordinates and intensity read zero, count is the expected value given
  function automatic step_row_t dropped_row(input logic [RANGE_W-1:0] r,
                                            input logic [INTEN_W-1:0] inten,
                                            input bit first, input bit last,
                                            input logic [COUNT_W-1:0] count);
    step_row_t t;
    t = sample_row(r, inten, first, last);
    t.typed = 1'b1;
    t.want.count = count;
    t.want.scan_end = last;
    return t;
  endfunction

  task automatic feed_sample(input step_row_t row);
    point_t guess;
    while (idle_on && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_range_mm <= row.range_mm;
    in_intensity <= row.intensity;
    in_first_sample <= row.first;
    in_last_sample <= row.last;
    do @(posedge clk); while (in_stall);
    guess = predict_point(row);
    pending_points.insert(pending_points.size(), row.typed ? row.want : guess);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_ANGLE_START: start_reg = data;
      REG_ANGLE_STEP:  step_reg = data;
      REG_RANGE_LIMIT: limit_reg = data[RANGE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [RANGE_W-1:0] pick_range();
    case ($urandom_range(19))
      0, 1: return '0;
      2: return RANGE_W'(limit_reg - 1'b1);
      3: return limit_reg;
      4: return '1;
      5, 6: return RANGE_W'($urandom_range(1, 16));
      7: return RANGE_W'($urandom_range(16'hFFFF));
      default: return (limit_reg > 1) ? RANGE_W'($urandom_range(1, limit_reg - 1))
                                      : RANGE_W'($urandom_range(16'hFFFF));
    endcase
  endfunction

  function automatic logic [ANGLE_W-1:0] pick_angle();
    logic [ANGLE_W-1:0] quarter;
    quarter = {2'($urandom_range(3)), 30'd0};
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return quarter + ANGLE_W'($urandom_range(2)) - 1'b1;
      // halfway between quarter turns, where the fold flips
      3: return quarter + 32'h2000_0000 + ANGLE_W'($urandom_range(2)) - 1'b1;
      default: return ANGLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [ANGLE_W-1:0] pick_step();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return ANGLE_W'($urandom_range(1, 1 << 20));
      3: return 32'h4000_0000;
      default: return ANGLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [RANGE_W-1:0] pick_limit();
    case ($urandom_range(9))
      0: return '0;
      1: return 16'd1;
      2, 3: return '1;
      4: return RANGE_W'($urandom_range(16'hFFFF));
      default: return RANGE_W'($urandom_range(1000, 16'hFFFF));
    endcase
  endfunction

  task automatic random_phase(input int budget);
    int sent;
    int len;
    bit first, last;
    sent = 0;
    while (sent < budget) begin
      len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 40);
      for (int k = 0; k < len; k++) begin
        first = (k == 0);
        last = (k == len - 1);
        // scramble the scan marks now and then
        if ($urandom_range(99) < 8) begin
          first = $urandom_range(1);
          last = $urandom_range(1);
        end
        feed_sample(sample_row(pick_range(), INTEN_W'($urandom_range(16'hFFFF)), first, last));
      end
      sent += len;
    end
  endtask

  initial begin : stimulus
    step_row_t plan[$];
    plan = '{
      dropped_row(16'd0, 16'hFFFF, 1'b0, 1'b0, 13'd0),
      sample_row(16'd1000, 16'h0000, 1'b0, 1'b0),
      dropped_row(16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 13'd1),
      reg_row(REG_RANGE_LIMIT, 32'd0),
      dropped_row(16'd1, 16'h1234, 1'b1, 1'b0, 13'd0),
      reg_row(REG_ANGLE_START, 32'hFFFF_FFFF),
      reg_row(REG_ANGLE_STEP, 32'h4000_0000),
      reg_row(REG_RANGE_LIMIT, 32'hFFFF_FFFF),
      sample_row(16'd65534, 16'hFFFF, 1'b1, 1'b0),
      sample_row(16'd65534, 16'h0000, 1'b0, 1'b0),
      sample_row(16'd65534, 16'h5A5A, 1'b0, 1'b0),
      sample_row(16'd65534, 16'hA5A5, 1'b0, 1'b1),
      reg_row(REG_ANGLE_START, 32'h2000_0000),
      reg_row(REG_ANGLE_STEP, 32'hFFFF_FFFF),
      sample_row(16'd1, 16'd1, 1'b1, 1'b0),
      sample_row(16'd30000, 16'd2, 1'b0, 1'b0),
      sample_row(16'd30000, 16'd3, 1'b0, 1'b1),
      reg_row(REG_ANGLE_START, 32'hE000_0000),
      reg_row(REG_ANGLE_STEP, 32'h2000_0000),
      sample_row(16'd50000, 16'd7, 1'b1, 1'b1),
      sample_row(16'd50000, 16'd8, 1'b0, 1'b0),
      dropped_row(16'd0, 16'd9, 1'b0, 1'b0, 13'd2),
      sample_row(16'd50000, 16'd10, 1'b0, 1'b0),
      reg_row(REG_RANGE_LIMIT, 32'd1),
      dropped_row(16'd1, 16'd11, 1'b1, 1'b0, 13'd0),
      reg_row(REG_RANGE_LIMIT, 32'd2),
      sample_row(16'd1, 16'd12, 1'b0, 1'b0),
      dropped_row(16'd2, 16'd13, 1'b0, 1'b0, 13'd1),
      reg_row(REG_UNUSED, 32'd0),
      sample_row(16'd1, 16'd14, 1'b0, 1'b0),
      // new start angle must wait for the next first sample
      reg_row(REG_ANGLE_START, 32'h8000_0000),
      sample_row(16'd1, 16'd15, 1'b0, 1'b0),
      sample_row(16'd1, 16'd16, 1'b1, 1'b1)
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        drain();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        feed_sample(plan[i]);
      end
    end

    for (int ph = 0; ph < 10; ph++) begin
      drain();
      idle_on = !(ph == 4 || ph == 5);
      write_reg(REG_ANGLE_START, pick_angle());
      write_reg(REG_ANGLE_STEP, pick_step());
      write_reg(REG_RANGE_LIMIT, {16'($urandom), pick_limit()});
      if ($urandom_range(3) == 0) write_reg(REG_UNUSED, $urandom);
      random_phase(100);
    end

    drain();
    repeat (CORDIC_STEPS + 8) @(posedge clk);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
